// ===== design/eqdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqdr_pkg
// Shared sizes, operation codes and controller states of the event queue.
// ----------------------------------------------------------------------------
package eqdr_pkg;

  localparam int NUM_EVENTS = 32;
  localparam int ID_W       = $clog2(NUM_EVENTS);

  typedef logic [ID_W-1:0] ev_id_t;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET_RD,
    ST_WALK,
    ST_WALK_RD,
    ST_FIX_RD,
    ST_RESP
  } state_t;

endpackage

// ===== design/event_queue_with_dedup_remove_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_queue_with_dedup_remove_unit
// FIFO of event handles kept as a linked list in a link memory, with
// duplicate suppression on put and removal of a named event.
// ----------------------------------------------------------------------------
// states: put, query, a miss on remove and get on an empty or single-entry
//   queue go from accept to ST_RESP; a longer get passes ST_GET_RD first
// remove hit: WALK/WALK_RD per entry ahead, then FIX_RD unless it is the tail
// handshake: one word in flight; the next is taken the cycle after the result
//   enters the output register
// reset: queue empty, all queued marks clear; link memory is not cleared
// ----------------------------------------------------------------------------
module event_queue_with_dedup_remove_unit
  import eqdr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_operation,
  input  logic [ID_W-1:0] in_event_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_got_valid,
  output logic [ID_W-1:0] out_got_event,
  output logic            out_accepted,
  output logic            out_queue_empty,
  output logic            out_event_queued
);

  state_t state_r, state_nxt;

  ev_id_t                head_r, head_nxt;
  ev_id_t                tail_r, tail_nxt;
  logic                  empty_r, empty_nxt;
  logic [NUM_EVENTS-1:0] marks_r, marks_nxt;

  ev_id_t id_r, id_nxt;
  ev_id_t cur_r, cur_nxt;
  ev_id_t prev_r, prev_nxt;
  logic   have_prev_r, have_prev_nxt;
  logic   res_got_r, res_got_nxt;
  ev_id_t res_gev_r, res_gev_nxt;
  logic   res_acc_r, res_acc_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_got_valid_r;
  ev_id_t out_got_event_r;
  logic   out_accepted_r;
  logic   out_queue_empty_r;
  logic   out_event_queued_r;

  ev_id_t link_mem [NUM_EVENTS];
  ev_id_t link_rd_r;
  logic   mem_we, mem_re;
  ev_id_t mem_waddr, mem_wdata, mem_raddr;

  logic accept, load_out, at_tail;

  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || out_ready);
  assign at_tail  = (cur_r == tail_r);

  // link memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rd_r <= link_mem[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESP;
          if (in_operation == OP_GET && !empty_r && head_r != tail_r) begin
            state_nxt = ST_GET_RD;
          end else if (in_operation == OP_REMOVE && !empty_r && marks_r[in_event_id]) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_GET_RD:  state_nxt = ST_RESP;
      ST_WALK: begin
        if (cur_r == id_r) begin
          state_nxt = at_tail ? ST_RESP : ST_FIX_RD;
        end else begin
          state_nxt = at_tail ? ST_RESP : ST_WALK_RD;
        end
      end
      ST_WALK_RD: state_nxt = ST_WALK;
      ST_FIX_RD:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    marks_nxt     = marks_r;
    id_nxt        = id_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    res_got_nxt   = res_got_r;
    res_gev_nxt   = res_gev_r;
    res_acc_nxt   = res_acc_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = in_event_id;
    mem_re        = 1'b0;
    mem_raddr     = head_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          id_nxt        = in_event_id;
          res_got_nxt   = 1'b0;
          res_gev_nxt   = '0;
          res_acc_nxt   = 1'b0;
          cur_nxt       = head_r;
          have_prev_nxt = 1'b0;
          case (in_operation)
            OP_PUT: begin
              if (!marks_r[in_event_id]) begin
                res_acc_nxt              = 1'b1;
                marks_nxt[in_event_id]   = 1'b1;
                tail_nxt                 = in_event_id;
                empty_nxt                = 1'b0;
                if (empty_r) begin
                  head_nxt = in_event_id;
                end else begin
                  mem_we = 1'b1;
                end
              end
            end
            OP_GET: begin
              if (!empty_r) begin
                res_got_nxt       = 1'b1;
                res_gev_nxt       = head_r;
                marks_nxt[head_r] = 1'b0;
                if (head_r == tail_r) begin
                  empty_nxt = 1'b1;
                end else begin
                  mem_re = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_GET_RD: begin
        head_nxt = link_rd_r;
      end
      ST_WALK: begin
        mem_raddr = cur_r;
        if (cur_r == id_r) begin
          if (at_tail) begin
            res_acc_nxt     = 1'b1;
            marks_nxt[id_r] = 1'b0;
            if (have_prev_r) begin
              tail_nxt = prev_r;
            end else begin
              empty_nxt = 1'b1;
            end
          end else begin
            mem_re = 1'b1;
          end
        end else if (!at_tail) begin
          mem_re = 1'b1;
        end
      end
      ST_WALK_RD: begin
        prev_nxt      = cur_r;
        have_prev_nxt = 1'b1;
        cur_nxt       = link_rd_r;
      end
      ST_FIX_RD: begin
        res_acc_nxt     = 1'b1;
        marks_nxt[id_r] = 1'b0;
        mem_waddr       = prev_r;
        mem_wdata       = link_rd_r;
        if (have_prev_r) begin
          mem_we = 1'b1;
        end else begin
          head_nxt = link_rd_r;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    res_got_r   <= res_got_nxt;
    res_gev_r   <= res_gev_nxt;
    res_acc_r   <= res_acc_nxt;
    if (load_out) begin
      out_got_valid_r    <= res_got_r;
      out_got_event_r    <= res_gev_r;
      out_accepted_r     <= res_acc_r;
      out_queue_empty_r  <= empty_r;
      out_event_queued_r <= marks_r[id_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_got_valid    = out_got_valid_r;
  assign out_got_event    = out_got_event_r;
  assign out_accepted     = out_accepted_r;
  assign out_queue_empty  = out_queue_empty_r;
  assign out_event_queued = out_event_queued_r;

endmodule
